// ===== hdl/assert_macros.svh =====
// assertion macros used by the positioner top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define RSMP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("rsmp assertion failed");
// condition in one cycle implies a consequence in the next cycle
`define RSMP_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error("rsmp assertion failed");
`else
`define RSMP_ASSERT(label, clk, rstn, prop)
`define RSMP_ASSERT_NEXT(label, clk, rstn, cond, cons)
`endif
`endif

// ===== hdl/rsmp_pkg.sv =====
// shared types and constants of the ring axis shortest move positioner
`default_nettype none
package rsmp_pkg;

    localparam int POS_BITS = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [POS_BITS-1:0] RING_PERIOD_RESET = 16'd65535;
    localparam logic [POS_BITS-1:0] DECEL_RESET = 16'd0;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_RANGE    = 3'd2,
        ST_THERE    = 3'd3,
        ST_TIE      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_FWD  = 2'd1,
        DRV_BWD  = 2'd2
    } drive_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RING_PERIOD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECEL_DISTANCE = 2'd1;

endpackage
`default_nettype wire

// ===== hdl/ring_axis_shortest_move_positioner_top.sv =====
// top level of the ring axis shortest move positioner
`default_nettype none
`include "assert_macros.svh"
// Positioner for a rotary axis whose encoder wraps at ring_period counts. Every
// input transfer carries the current encoder count and, when s_cmd_valid is set,
// a move command with a target. A command picks the shorter way round the ring,
// sets a brake point (braking distance halved on short trips) and drives forward
// or backward; every transfer then checks the brake point and stops the drive
// with m_done_res when it is passed. Exactly one result transfer leaves for each
// input transfer, in order. Rate: one item per clock cycle sustained while m_ready
// holds; each item passes the input register, then the result register, and
// the command decode, distance and brake point arithmetic and the stop check sit
// in one combinational pass between those two registers. Configuration writes
// (index 0 ring_period, 1 decel_distance, other indexes ignored) are always
// taken, and are meant for when no item is in flight.
module ring_axis_shortest_move_positioner_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rsmp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rsmp_pkg::POS_BITS-1:0]      cfg_data,
    // input item channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [rsmp_pkg::POS_BITS-1:0]      s_position,
    input  wire logic                               s_cmd_valid,
    input  wire logic [rsmp_pkg::POS_BITS-1:0]      s_target,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [2:0]                              m_cmd_status,
    output logic [1:0]                              m_drive,
    output logic                                    m_done_res,
    output logic [rsmp_pkg::POS_BITS-1:0]           m_brake_at
);

    localparam int PB = rsmp_pkg::POS_BITS;

    // configuration registers
    logic [PB-1:0] ring_period_reg;
    logic [PB-1:0] decel_reg;

    // input register
    logic          in_valid_reg;
    logic [PB-1:0] in_pos_reg;
    logic          in_cmd_reg;
    logic [PB-1:0] in_tgt_reg;

    // positioner state
    rsmp_pkg::drive_t direction_reg;
    rsmp_pkg::drive_t direction_next;
    logic [PB-1:0]    brake_point_reg;
    logic [PB-1:0]    brake_point_next;
    logic [PB-1:0]    goal_reg;
    logic [PB-1:0]    goal_next;

    // result register
    logic              out_valid_reg;
    rsmp_pkg::status_t out_status_reg;
    rsmp_pkg::drive_t  out_drive_reg;
    logic              out_done_reg;
    logic [PB-1:0]     out_brake_reg;

    // combinational pass
    rsmp_pkg::status_t status_next;
    rsmp_pkg::drive_t  dir_cmd;
    rsmp_pkg::drive_t  dir_pick;
    logic              done_next;
    logic              advance;
    logic              in_range;
    logic [PB-1:0]     fwd_dist;
    logic [PB-1:0]     bwd_dist;
    logic [PB-1:0]     trip;
    logic [PB-1:0]     brk;
    logic [PB-1:0]     room;
    logic [PB-1:0]     bp_cmd;
    logic [PB-1:0]     goal_cmd;

    // handshakes: result register frees when empty or taken, input register
    // refills whenever its item moves on
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_period_reg <= rsmp_pkg::RING_PERIOD_RESET;
            decel_reg       <= rsmp_pkg::DECEL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rsmp_pkg::CFG_RING_PERIOD:    ring_period_reg <= cfg_data;
                rsmp_pkg::CFG_DECEL_DISTANCE: decel_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // command decode and distances, all wrapping at the port width
    always_comb begin
        in_range = (in_tgt_reg != '0) && (in_tgt_reg < ring_period_reg);
        if (in_pos_reg < in_tgt_reg) begin
            fwd_dist = in_tgt_reg - in_pos_reg;
            bwd_dist = ring_period_reg - in_tgt_reg + in_pos_reg;
        end else begin
            fwd_dist = ring_period_reg - in_pos_reg + in_tgt_reg;
            bwd_dist = in_pos_reg - in_tgt_reg;
        end

        dir_pick = (fwd_dist > bwd_dist) ? rsmp_pkg::DRV_BWD : rsmp_pkg::DRV_FWD;
        trip     = (dir_pick == rsmp_pkg::DRV_FWD) ? fwd_dist : bwd_dist;

        // short trip: brake at half way
        if ({1'b0, trip} < {decel_reg, 1'b0}) begin
            brk = trip >> 1;
        end else begin
            brk = decel_reg;
        end

        room = ring_period_reg - in_tgt_reg;
        if (dir_pick == rsmp_pkg::DRV_FWD) begin
            if (brk > in_tgt_reg) begin
                bp_cmd = ring_period_reg - (brk - in_tgt_reg);
            end else begin
                bp_cmd = in_tgt_reg - brk;
            end
        end else begin
            if (brk > room) begin
                bp_cmd = brk - room;
            end else begin
                bp_cmd = in_tgt_reg + brk;
            end
        end

        // state after the command part
        status_next      = rsmp_pkg::ST_NONE;
        dir_cmd          = direction_reg;
        brake_point_next = brake_point_reg;
        goal_cmd         = goal_reg;
        if (in_cmd_reg) begin
            if (!in_range) begin
                status_next = rsmp_pkg::ST_RANGE;
            end else if (in_pos_reg == in_tgt_reg) begin
                status_next = rsmp_pkg::ST_THERE;
            end else if (fwd_dist == bwd_dist) begin
                status_next = rsmp_pkg::ST_TIE;
                goal_cmd    = in_tgt_reg;
                dir_cmd     = rsmp_pkg::DRV_STOP;
            end else begin
                status_next      = rsmp_pkg::ST_ACCEPTED;
                goal_cmd         = in_tgt_reg;
                dir_cmd          = dir_pick;
                brake_point_next = bp_cmd;
            end
        end
        goal_next = goal_cmd;

        // stop check on the same position, taking the wrap of the brake point
        case (dir_cmd)
            rsmp_pkg::DRV_FWD: begin
                if (brake_point_next < goal_cmd) begin
                    done_next = in_pos_reg >= brake_point_next;
                end else if (brake_point_next > goal_cmd) begin
                    done_next = (in_pos_reg >= brake_point_next) || (in_pos_reg < goal_cmd);
                end else begin
                    done_next = in_pos_reg == brake_point_next;
                end
            end
            rsmp_pkg::DRV_BWD: begin
                if (brake_point_next > goal_cmd) begin
                    done_next = in_pos_reg <= brake_point_next;
                end else if (brake_point_next < goal_cmd) begin
                    done_next = (in_pos_reg <= brake_point_next) || (in_pos_reg > goal_cmd);
                end else begin
                    done_next = in_pos_reg == brake_point_next;
                end
            end
            default: done_next = 1'b0;
        endcase

        direction_next = done_next ? rsmp_pkg::DRV_STOP : dir_cmd;
    end

    // input register, state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            direction_reg   <= rsmp_pkg::DRV_STOP;
            brake_point_reg <= '0;
            goal_reg        <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                direction_reg   <= direction_next;
                brake_point_reg <= brake_point_next;
                goal_reg        <= goal_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_ready && s_valid) begin
            in_pos_reg <= s_position;
            in_cmd_reg <= s_cmd_valid;
            in_tgt_reg <= s_target;
        end
        if (advance) begin
            out_status_reg <= status_next;
            out_drive_reg  <= direction_next;
            out_done_reg   <= done_next;
            out_brake_reg  <= brake_point_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_cmd_status = out_status_reg;
    assign m_drive      = out_drive_reg;
    assign m_done_res   = out_done_reg;
    assign m_brake_at   = out_brake_reg;

    // a stop flag always comes with a stopped drive
    `RSMP_ASSERT(a_done_stops, aclk, aresetn,
        !(m_valid && m_done_res && (m_drive != rsmp_pkg::DRV_STOP)))
    // the shown drive matches the held direction state
    `RSMP_ASSERT(a_drive_state, aclk, aresetn,
        !m_valid || (m_drive == direction_reg))
    // only an accepted command moves the brake point
    `RSMP_ASSERT_NEXT(a_brake_hold, aclk, aresetn,
        advance && (status_next != rsmp_pkg::ST_ACCEPTED), $stable(brake_point_reg))
    // a waiting input item is never dropped
    `RSMP_ASSERT_NEXT(a_in_hold, aclk, aresetn,
        in_valid_reg && !advance, in_valid_reg)

endmodule
`default_nettype wire

// ===== tb/tb_ring_axis_shortest_move_positioner_top.sv =====
// self-checking testbench for the ring axis shortest move positioner top level
`timescale 1ns / 100ps
module tb_ring_axis_shortest_move_positioner_top;
    import rsmp_pkg::*;

    // no transfer on any channel for this many cycles ends the run
    localparam int QUIET_LIMIT = 2000;
    // length of the forced result back-pressure stretch
    localparam int HOLD_CYCLES = 40;
    localparam logic [31:0] WRAP_MASK = (32'd1 << POS_BITS) - 32'd1;
    // register index that the block ignores
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        status_t               status;
        drive_t                drive;
        logic                  done;
        logic [POS_BITS-1:0]   brake;
    } result_t;

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = CFG_RING_PERIOD;
    logic [POS_BITS-1:0]       cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [POS_BITS-1:0]       s_position = '0;
    logic                      s_cmd_valid = 1'b0;
    logic [POS_BITS-1:0]       s_target = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [2:0]                m_cmd_status;
    logic [1:0]                m_drive;
    logic                      m_done_res;
    logic [POS_BITS-1:0]       m_brake_at;

    // shadow of the positioner: registers and motion state
    logic [POS_BITS-1:0]       period_q = RING_PERIOD_RESET;
    logic [POS_BITS-1:0]       decel_q = DECEL_RESET;
    drive_t                    drive_q = DRV_STOP;
    logic [POS_BITS-1:0]       brake_q = '0;
    logic [POS_BITS-1:0]       goal_q = '0;

    result_t                   expected_results[$];
    int                        errors = 0;
    int                        quiet_cycles = 0;
    bit                        idle_on = 1'b1;
    bit                        hold_req = 1'b0;

    ring_axis_shortest_move_positioner_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_position   (s_position),
        .s_cmd_valid  (s_cmd_valid),
        .s_target     (s_target),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cmd_status (m_cmd_status),
        .m_drive      (m_drive),
        .m_done_res   (m_done_res),
        .m_brake_at   (m_brake_at)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // works out the result of one sample and moves the shadow state on
    function automatic result_t predict_positioner(input logic [POS_BITS-1:0] pos,
                                                   input logic cmd,
                                                   input logic [POS_BITS-1:0] tgt);
        result_t     r;
        logic [31:0] fwd;
        logic [31:0] bwd;
        logic [31:0] brk;
        logic [31:0] wrapped;
        logic        reached;
        r.status = ST_NONE;
        if (cmd) begin
            if (tgt == '0 || tgt >= period_q) begin
                r.status = ST_RANGE;
            end else if (pos == tgt) begin
                r.status = ST_THERE;
            end else begin
                // both distances wrap at the position width, as the subtracters do
                if (pos < tgt) begin
                    fwd = 32'(tgt) - 32'(pos);
                    bwd = (32'(period_q) - 32'(tgt) + 32'(pos)) & WRAP_MASK;
                end else begin
                    fwd = (32'(period_q) - 32'(pos) + 32'(tgt)) & WRAP_MASK;
                    bwd = 32'(pos) - 32'(tgt);
                end
                goal_q = tgt;
                brk = 32'(decel_q);
                if (fwd == bwd) begin
                    // tie: stop, brake point untouched
                    drive_q = DRV_STOP;
                    r.status = ST_TIE;
                end else if (fwd < bwd) begin
                    if (fwd < 2 * brk) brk = fwd / 2;
                    if (brk > 32'(tgt)) wrapped = 32'(period_q) - (brk - 32'(tgt));
                    else wrapped = 32'(tgt) - brk;
                    brake_q = wrapped[POS_BITS-1:0];
                    drive_q = DRV_FWD;
                    r.status = ST_ACCEPTED;
                end else begin
                    if (bwd < 2 * brk) brk = bwd / 2;
                    if (brk > 32'(period_q) - 32'(tgt))
                        wrapped = brk - (32'(period_q) - 32'(tgt));
                    else
                        wrapped = 32'(tgt) + brk;
                    brake_q = wrapped[POS_BITS-1:0];
                    drive_q = DRV_BWD;
                    r.status = ST_ACCEPTED;
                end
            end
        end
        // stop check on the same position, after any command
        reached = 1'b0;
        case (drive_q)
            DRV_FWD: begin
                if (brake_q < goal_q) reached = (pos >= brake_q);
                else if (brake_q > goal_q) reached = (pos >= brake_q) || (pos < goal_q);
                else reached = (pos == brake_q);
            end
            DRV_BWD: begin
                if (brake_q > goal_q) reached = (pos <= brake_q);
                else if (brake_q < goal_q) reached = (pos <= brake_q) || (pos > goal_q);
                else reached = (pos == brake_q);
            end
            default: ;
        endcase
        if (reached) drive_q = DRV_STOP;
        r.done = reached;
        r.drive = drive_q;
        r.brake = brake_q;
        return r;
    endfunction

    // offers one sample and waits for its transfer
    task automatic offer_sample(input logic [POS_BITS-1:0] pos, input logic cmd,
                                input logic [POS_BITS-1:0] tgt);
        if (idle_on && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 34);
        end
        s_valid <= 1'b1;
        s_position <= pos;
        s_cmd_valid <= cmd;
        s_target <= tgt;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_positioner(pos, cmd, tgt));
    endtask

    // register write, only once every pending result has come back
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [POS_BITS-1:0] value);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_RING_PERIOD) period_q = value;
        else if (idx == CFG_DECEL_DISTANCE) decel_q = value;
    endtask

    // reset values: full 16-bit ring, no braking distance
    task automatic test_reset_defaults();
        offer_sample(16'd0, 1'b0, 16'hffff);
        offer_sample(16'd10, 1'b1, 16'd0);          // target zero rejected
        offer_sample(16'd10, 1'b1, 16'hffff);       // target on the period rejected
        offer_sample(16'hffff, 1'b1, 16'd1);        // from outside the ring, brake point on goal
        offer_sample(16'd0, 1'b0, 16'd0);
        offer_sample(16'd1, 1'b0, 16'd0);           // stops only on equality
    endtask

    // short trips and moves across the wrap on a 100 count ring
    task automatic test_short_and_wrapped_moves();
        write_reg(CFG_RING_PERIOD, 16'd100);
        write_reg(CFG_DECEL_DISTANCE, 16'd10);
        offer_sample(16'd10, 1'b1, 16'd50);
        offer_sample(16'd40, 1'b0, 16'd0);
        offer_sample(16'd45, 1'b1, 16'd50);         // braking distance halved
        offer_sample(16'd48, 1'b0, 16'd0);
        offer_sample(16'd95, 1'b1, 16'd3);          // forward through zero
        offer_sample(16'd97, 1'b0, 16'd0);
        offer_sample(16'd2, 1'b0, 16'd0);
        offer_sample(16'd5, 1'b1, 16'd99);          // backward through zero
        offer_sample(16'd3, 1'b0, 16'd0);
        offer_sample(16'd1, 1'b0, 16'd0);
    endtask

    task automatic test_tie_and_already_there();
        offer_sample(16'd0, 1'b1, 16'd50);          // equal distances both ways
        offer_sample(16'd20, 1'b1, 16'd20);
        offer_sample(16'd120, 1'b1, 16'd30);        // position beyond the period
    endtask

    // a fresh command replaces a drive that is still running
    task automatic test_new_command_while_moving();
        offer_sample(16'd10, 1'b1, 16'd40);
        offer_sample(16'd20, 1'b1, 16'd5);
        offer_sample(16'd12, 1'b0, 16'd0);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_RING_PERIOD, 16'd0);          // every command rejected
        offer_sample(16'd0, 1'b1, 16'd1);
        write_reg(CFG_RING_PERIOD, 16'd1);
        offer_sample(16'd0, 1'b1, 16'd1);
        write_reg(CFG_RING_PERIOD, 16'hffff);
        write_reg(CFG_DECEL_DISTANCE, 16'hffff);
        write_reg(CFG_SPARE, 16'h1234);             // ignored index
        offer_sample(16'd0, 1'b1, 16'd32767);
        offer_sample(16'd16384, 1'b0, 16'hffff);
    endtask

    // commands followed by encoder walks towards the brake point, with some noise
    task automatic test_random_moves(input int per_cfg, input int dec_cfg, input int n,
                                     input bit idle, input bit hold);
        int                  per;
        int                  span;
        int                  p;
        int                  step;
        int                  gap;
        int                  sent;
        int                  steps;
        int                  r;
        logic [POS_BITS-1:0] tgt;
        write_reg(CFG_RING_PERIOD, per_cfg[POS_BITS-1:0]);
        write_reg(CFG_DECEL_DISTANCE, dec_cfg[POS_BITS-1:0]);
        idle_on = idle;
        if (hold) hold_req = 1'b1;
        per = int'(period_q);
        span = per / 16 + 1;
        sent = 0;
        if (per >= 2) p = $urandom_range(per - 1);
        else p = $urandom_range(16'hffff);
        while (sent < n) begin
            r = $urandom_range(99);
            if (per < 2 || r < 8) tgt = POS_BITS'($urandom_range(16'hffff));
            else if (r < 12) tgt = p[POS_BITS-1:0];
            else if (r < 16 && per % 2 == 0) tgt = POS_BITS'((p + per / 2) % per);
            else tgt = POS_BITS'($urandom_range(per - 1, 1));
            if (r >= 95 || per < 2) p = $urandom_range(16'hffff);
            offer_sample(p[POS_BITS-1:0], 1'b1, tgt);
            sent++;
            steps = 0;
            while (per >= 1 && drive_q != DRV_STOP && steps < 80 && sent < n) begin
                step = $urandom_range(span, 1);
                if (drive_q == DRV_FWD) gap = ((int'(brake_q) - p) % per + per) % per;
                else gap = ((p - int'(brake_q)) % per + per) % per;
                // now and then land right on the brake point
                if (gap >= 1 && gap <= span && $urandom_range(1) == 1) step = gap;
                if (drive_q == DRV_FWD) p = (p + step) % per;
                else p = ((p - step) % per + per) % per;
                if ($urandom_range(99) < 5)
                    offer_sample(p[POS_BITS-1:0], 1'b1, POS_BITS'($urandom_range(16'hffff)));
                else
                    offer_sample(p[POS_BITS-1:0], 1'b0, POS_BITS'($urandom_range(16'hffff)));
                sent++;
                steps++;
            end
            if (per >= 2 && p >= per) p = $urandom_range(per - 1);
        end
        idle_on = 1'b1;
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !idle_on || ($urandom_range(99) >= 34);
        end
    end

    // compares every result transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status %0d drive %0d done %0d brake %0d",
                         $time, m_cmd_status, m_drive, m_done_res, m_brake_at);
            end else begin
                want = expected_results.pop_front();
                if (m_cmd_status !== want.status) begin
                    errors++;
                    $display("%0t: cmd_status expected %0d got %0d",
                             $time, want.status, m_cmd_status);
                end
                if (m_drive !== want.drive) begin
                    errors++;
                    $display("%0t: drive expected %0d got %0d", $time, want.drive, m_drive);
                end
                if (m_done_res !== want.done) begin
                    errors++;
                    $display("%0t: done_res expected %0d got %0d",
                             $time, want.done, m_done_res);
                end
                if (m_brake_at !== want.brake) begin
                    errors++;
                    $display("%0t: brake_at expected %0d got %0d",
                             $time, want.brake, m_brake_at);
                end
            end
        end
    end

    // cycles since the last transfer on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int per;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_short_and_wrapped_moves();
        test_tie_and_already_there();
        test_new_command_while_moving();
        test_register_extremes();
        // full ring, both braking extremes
        test_random_moves(65535, 0, 80, 1'b1, 1'b0);
        test_random_moves(65535, 65535, 70, 1'b1, 1'b0);
        // long stretch with both sides always ready
        test_random_moves(65535, $urandom_range(4000), 80, 1'b0, 1'b0);
        // small ring while the result side holds off
        per = $urandom_range(300, 2);
        test_random_moves(per, $urandom_range(per), 90, 1'b1, 1'b1);
        per = $urandom_range(65535, 300);
        test_random_moves(per, $urandom_range(per / 4), 90, 1'b1, 1'b0);
        // even ring so that ties turn up
        per = 2 * $urandom_range(150, 2);
        test_random_moves(per, $urandom_range(per / 2), 80, 1'b1, 1'b0);
        test_random_moves(2, 1, 40, 1'b1, 1'b0);
        test_random_moves(3, 65535, 40, 1'b1, 1'b0);
        test_random_moves(1, 0, 20, 1'b1, 1'b0);
        test_random_moves(0, 5, 20, 1'b1, 1'b0);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
